FILE: design/mcd_pkg.sv
// shared widths, action codes and the fnv-1a hash step for the change detector
`default_nettype none

package mcd_pkg;

    localparam int NUM_TOPICS_DEF = 16;
    localparam int MAX_LEN_DEF    = 256;

    localparam int ACTION_W = 2;
    localparam int TOPIC_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 9;
    localparam int THR_W    = 9;
    localparam int HASH_W   = 64;

    localparam logic [ACTION_W-1:0] ACT_BYTE      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_ALL = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_EMPTY     = 2'd3;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // xor in the byte, then multiply by the prime 2^40 + 0x1b3 as shifts and adds
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

FILE: design/mcd_if.sv
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface mcd_in_if;
    logic                         valid;
    logic                         ready;
    logic [mcd_pkg::ACTION_W-1:0] action;
    logic [mcd_pkg::TOPIC_W-1:0]  topic;
    logic [mcd_pkg::BYTE_W-1:0]   data_byte;
    logic                         last;

    modport source (output valid, action, topic, data_byte, last, input ready);
    modport sink   (input valid, action, topic, data_byte, last, output ready);
endinterface

interface mcd_out_if;
    logic                        valid;
    logic                        ready;
    logic [mcd_pkg::TOPIC_W-1:0] result_topic;
    logic                        changed;
    logic                        overflow;
    logic [mcd_pkg::LEN_W-1:0]   message_length;

    modport source (output valid, result_topic, changed, overflow, message_length,
                    input ready);
    modport sink   (input valid, result_topic, changed, overflow, message_length,
                    output ready);
endinterface

`default_nettype wire

FILE: design/mcd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mcd_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/message_change_detector.sv
// message change detector: per-topic fnv-1a hash and byte-diff against a cached copy
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        action, topic, data_byte, last
//   o_out     out  valid/ready        result_topic, changed, overflow, message_length
//   i_cfg     in   i_cfg_we (no wait) i_cfg_wdata = diff_threshold
//
// one item per cycle while ready is high; the payload ram read and write are issued at the accept edge,
// the compare and change decision run the next cycle against the registered read data.
// a result enters the four-entry output queue at the edge after its final item is accepted.
// ready drops only when the queue plus the item in the compare stage could fill it.
// reset is synchronous: valid bits, bank selects and the queue clear at once, no ram pass.
`default_nettype none

module message_change_detector #(
    parameter int NUM_TOPICS = mcd_pkg::NUM_TOPICS_DEF,
    parameter int MAX_LEN    = mcd_pkg::MAX_LEN_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mcd_pkg::THR_W-1:0] i_cfg_wdata,
    mcd_in_if.sink                         i_in,
    mcd_out_if.source                      o_out
);

    localparam int TW        = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
    localparam int LW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LENW      = $clog2(MAX_LEN + 1);
    localparam int HW        = mcd_pkg::HASH_W;
    localparam int THW       = mcd_pkg::THR_W;
    localparam int OTW       = mcd_pkg::TOPIC_W;
    localparam int OLW       = mcd_pkg::LEN_W;
    localparam int CMPW      = (LENW > THW) ? LENW : THW;
    localparam int NTIN      = 2 ** mcd_pkg::TOPIC_W;
    localparam int PAY_DEPTH = NUM_TOPICS * 2 * (2 ** LW);
    localparam int PAW       = $clog2(PAY_DEPTH);
    localparam int META_W    = HW + LENW;
    localparam int QD        = 4;
    localparam int QAW       = 2;
    localparam int QCW       = 3;

    typedef struct packed {
        logic [OTW-1:0] result_topic;
        logic           changed;
        logic           overflow;
        logic [OLW-1:0] message_length;
    } t_result;

    // topic field folded into the configured number of topics
    logic [TW-1:0] topic_map [NTIN];
    for (genvar g = 0; g < NTIN; g++) begin : g_tmap
        assign topic_map[g] = TW'(g % NUM_TOPICS);
    end

    // config and per-topic flags
    logic [THW-1:0]        r_thr;
    logic [NUM_TOPICS-1:0] r_valid;
    logic [NUM_TOPICS-1:0] r_bank;

    // running message state
    logic            r_in_msg;
    logic [TW-1:0]   r_cur_topic;
    logic [HW-1:0]   r_hash;
    logic [LENW-1:0] r_len;
    logic            r_over;
    logic [LENW-1:0] r_diff;

    // compare stage
    logic            r_b_valid;
    logic [TW-1:0]   r_b_topic;
    logic            r_b_keep;
    logic [LW-1:0]   r_b_pos;
    logic            r_b_first;
    logic            r_b_end;
    logic [HW-1:0]   r_b_hash;
    logic [LENW-1:0] r_b_len;
    logic            r_b_over;
    logic [7:0]      r_b_byte;
    logic            r_fwd_hit;
    logic [META_W-1:0] r_fwd_meta;

    // output queue
    t_result        r_q [QD];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;

    // accept-side decode
    logic            acc;
    logic [TW-1:0]   in_t;
    logic            is_byte;
    logic            is_empty;
    logic            is_clr;
    logic            is_clr_all;
    logic            start;
    logic [TW-1:0]   a_topic;
    logic [HW-1:0]   base_hash;
    logic [LENW-1:0] base_len;
    logic            base_over;
    logic            keep;
    logic [LW-1:0]   a_pos;
    logic            a_end;
    logic            a_goes_b;
    logic            bank_a;
    logic [HW-1:0]   n_hash;
    logic [LENW-1:0] n_len;
    logic            n_over;

    // compare-side decode
    logic [META_W-1:0] meta_rdata;
    logic [META_W-1:0] meta;
    logic [HW-1:0]     s_hash;
    logic [LENW-1:0]   s_len;
    logic [7:0]        pay_rdata;
    logic              ev;
    logic              byte_diff;
    logic [LENW-1:0]   n_diff;
    logic              cnt_chg;
    logic              chg;
    logic              b_commit;
    logic              push;
    logic              pop;
    t_result           res;
    logic [NUM_TOPICS-1:0] n_valid;

    assign acc        = i_in.valid && i_in.ready;
    assign in_t       = topic_map[i_in.topic];
    assign is_byte    = (i_in.action == mcd_pkg::ACT_BYTE);
    assign is_empty   = (i_in.action == mcd_pkg::ACT_EMPTY);
    assign is_clr     = (i_in.action == mcd_pkg::ACT_CLEAR);
    assign is_clr_all = (i_in.action == mcd_pkg::ACT_CLEAR_ALL);

    always_comb begin
        start     = is_empty || (is_byte && !r_in_msg);
        a_topic   = start ? in_t : r_cur_topic;
        base_hash = start ? mcd_pkg::FNV_BASIS : r_hash;
        base_len  = start ? '0 : r_len;
        base_over = start ? 1'b0 : r_over;
        keep      = is_byte && (base_len < LENW'(MAX_LEN));
        a_pos     = base_len[LW-1:0];
        a_end     = is_empty || (is_byte && i_in.last);
        a_goes_b  = is_byte || is_empty;
        n_hash    = keep ? mcd_pkg::fnv_step(base_hash, i_in.data_byte) : base_hash;
        n_len     = keep ? base_len + LENW'(1) : base_len;
        n_over    = base_over || (is_byte && !keep);
        // a commit to the same topic this edge flips the bank the new item sees
        bank_a    = r_bank[a_topic] ^ (b_commit && (r_b_topic == a_topic));
    end

    mcd_ram #(
        .WIDTH (8),
        .DEPTH (PAY_DEPTH)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (acc && keep),
        .i_waddr (PAW'({a_topic, ~bank_a, a_pos})),
        .i_wdata (i_in.data_byte),
        .i_raddr (PAW'({a_topic, bank_a, a_pos})),
        .o_rdata (pay_rdata)
    );

    mcd_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_TOPICS)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (b_commit),
        .i_waddr (r_b_topic),
        .i_wdata ({r_b_hash, r_b_len}),
        .i_raddr (a_topic),
        .o_rdata (meta_rdata)
    );

    always_comb begin
        meta      = r_fwd_hit ? r_fwd_meta : meta_rdata;
        s_hash    = meta[META_W-1:LENW];
        s_len     = meta[LENW-1:0];
        ev        = r_valid[r_b_topic];
        byte_diff = r_b_keep && ev && (LENW'(r_b_pos) < s_len) && (pay_rdata != r_b_byte);
        n_diff    = (r_b_first ? '0 : r_diff) + LENW'(byte_diff);
        if (r_thr != '0) begin
            cnt_chg = CMPW'(n_diff) > CMPW'(r_thr);
        end else begin
            cnt_chg = (n_diff != '0);
        end
        chg      = !ev || r_b_over || (s_hash != r_b_hash) || (s_len != r_b_len) || cnt_chg;
        b_commit = r_b_valid && r_b_end && chg;
        push     = r_b_valid && r_b_end;
        pop      = o_out.valid && o_out.ready;
        res.result_topic   = OTW'(r_b_topic);
        res.changed        = chg;
        res.overflow       = r_b_over;
        res.message_length = OLW'(r_b_len);
        // clears come after the finishing item in order, so they win
        n_valid = r_valid;
        if (b_commit) begin
            n_valid[r_b_topic] = 1'b1;
        end
        if (acc && is_clr) begin
            n_valid[in_t] = 1'b0;
        end
        if (acc && is_clr_all) begin
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_valid   <= '0;
            r_bank    <= '0;
            r_in_msg  <= 1'b0;
            r_b_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (b_commit) begin
                r_bank[r_b_topic] <= ~r_bank[r_b_topic];
            end
            r_valid <= n_valid;
            if (acc && a_goes_b) begin
                r_in_msg <= is_byte && !i_in.last;
            end
            r_b_valid <= acc && a_goes_b;
            r_fwd_hit <= b_commit && (r_b_topic == a_topic);
            r_wp      <= r_wp + QAW'(push);
            r_rp      <= r_rp + QAW'(pop);
            r_cnt     <= r_cnt + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && a_goes_b) begin
            r_cur_topic <= a_topic;
            r_hash      <= n_hash;
            r_len       <= n_len;
            r_over      <= n_over;
            r_b_topic   <= a_topic;
            r_b_keep    <= keep;
            r_b_pos     <= a_pos;
            r_b_first   <= start;
            r_b_end     <= a_end;
            r_b_hash    <= n_hash;
            r_b_len     <= n_len;
            r_b_over    <= n_over;
            r_b_byte    <= i_in.data_byte;
        end
        if (r_b_valid) begin
            r_diff <= n_diff;
        end
        r_fwd_meta <= {r_b_hash, r_b_len};
        if (push) begin
            r_q[r_wp] <= res;
        end
    end

    // room for the item in the compare stage and one more
    assign i_in.ready = (r_cnt + QCW'(r_b_valid && r_b_end)) < QCW'(QD);

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.result_topic   = r_q[r_rp].result_topic;
    assign o_out.changed        = r_q[r_rp].changed;
    assign o_out.overflow       = r_q[r_rp].overflow;
    assign o_out.message_length = r_q[r_rp].message_length;

endmodule

`default_nettype wire

FILE: design/mcd_checker.sv
// port-level checks for the message change detector, bound to the top level
`default_nettype none

module mcd_checker #(
    parameter int MAX_LEN = mcd_pkg::MAX_LEN_DEF
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [mcd_pkg::TOPIC_W-1:0] i_result_topic,
    input wire logic                        i_changed,
    input wire logic                        i_overflow,
    input wire logic [mcd_pkg::LEN_W-1:0]   i_message_length
);

    localparam int OLW = mcd_pkg::LEN_W;

    // a waiting result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_result_topic, i_changed, i_overflow, i_message_length}))
        else $error("result item changed while stalled");

    // a truncated message always counts as changed
    a_over_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> i_changed)
        else $error("overflowed item not reported as changed");

    // a truncated message reports the full kept length
    a_over_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> i_message_length == OLW'(MAX_LEN))
        else $error("overflowed item with short length");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item present after reset");

endmodule

bind message_change_detector mcd_checker #(
    .MAX_LEN (MAX_LEN)
) u_mcd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_result_topic   (o_out.result_topic),
    .i_changed        (o_out.changed),
    .i_overflow       (o_out.overflow),
    .i_message_length (o_out.message_length)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for the message change detector: random and directed traffic against a local model
`default_nettype none

module tb_top;

    localparam int NUM_TOPICS    = mcd_pkg::NUM_TOPICS_DEF;
    localparam int MAX_LEN       = mcd_pkg::MAX_LEN_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 3000;
    localparam int PRINT_LIMIT   = 40;
    localparam int RANDOM_ITEMS  = 35;

    localparam logic [mcd_pkg::HASH_W-1:0] HASH_PRIME = 64'h0000_0100_0000_01b3;

    typedef bit [mcd_pkg::BYTE_W-1:0] t_byte_q [$];

    typedef struct packed {
        logic [mcd_pkg::TOPIC_W-1:0] topic;
        logic                        changed;
        logic                        overflow;
        logic [mcd_pkg::LEN_W-1:0]   msg_length;
    } t_verdict;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [mcd_pkg::THR_W-1:0] cfg_wdata;

    mcd_in_if  in_if();
    mcd_out_if out_if();

    message_change_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // local copy of the detector state
    bit                          cache_valid [NUM_TOPICS];
    bit [mcd_pkg::HASH_W-1:0]    cache_hash  [NUM_TOPICS];
    int                          cache_len   [NUM_TOPICS];
    bit                          cache_bank  [NUM_TOPICS];
    bit [mcd_pkg::BYTE_W-1:0]    cache_bytes [NUM_TOPICS][2][MAX_LEN];
    bit [mcd_pkg::HASH_W-1:0]    msg_hash = mcd_pkg::FNV_BASIS;
    int                          msg_len;
    int                          msg_diffs;
    bit                          msg_open;
    bit                          msg_overflow;
    bit [mcd_pkg::TOPIC_W-1:0]   msg_topic;
    int                          diff_limit;

    t_verdict pending_verdicts [$];
    int       error_count;
    int       items_sent;
    int       quiet_cycles;
    int       burst_left;
    bit       steady_send;
    bit       hold_request;
    t_byte_q  recent_msgs [NUM_TOPICS];

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic open_message(input logic [mcd_pkg::TOPIC_W-1:0] t);
        msg_topic    = t;
        msg_hash     = mcd_pkg::FNV_BASIS;
        msg_len      = 0;
        msg_diffs    = 0;
        msg_overflow = 1'b0;
    endtask

    task automatic close_message();
        t_verdict v;
        bit chg;
        if (!cache_valid[msg_topic] || msg_overflow || cache_hash[msg_topic] != msg_hash ||
            cache_len[msg_topic] != msg_len)
            chg = 1'b1;
        else if (diff_limit != 0)
            chg = msg_diffs > diff_limit;
        else
            chg = msg_diffs != 0;
        if (chg) begin
            cache_valid[msg_topic] = 1'b1;
            cache_hash[msg_topic]  = msg_hash;
            cache_len[msg_topic]   = msg_len;
            cache_bank[msg_topic]  = ~cache_bank[msg_topic];
        end
        v.topic      = msg_topic;
        v.changed    = chg;
        v.overflow   = msg_overflow;
        v.msg_length = mcd_pkg::LEN_W'(msg_len);
        pending_verdicts = {pending_verdicts, v};
        msg_open = 1'b0;
    endtask

    task automatic detect_change(input logic [mcd_pkg::ACTION_W-1:0] act,
                                 input logic [mcd_pkg::TOPIC_W-1:0] t,
                                 input logic [mcd_pkg::BYTE_W-1:0] b, input logic is_last);
        case (act)
            mcd_pkg::ACT_CLEAR: begin
                cache_valid[t] = 1'b0;
            end
            mcd_pkg::ACT_CLEAR_ALL: begin
                foreach (cache_valid[i]) cache_valid[i] = 1'b0;
            end
            mcd_pkg::ACT_EMPTY: begin
                open_message(t);
                close_message();
            end
            default: begin
                if (!msg_open) begin
                    open_message(t);
                    msg_open = 1'b1;
                end
                if (msg_len < MAX_LEN) begin
                    msg_hash = (msg_hash ^ {{(mcd_pkg::HASH_W-mcd_pkg::BYTE_W){1'b0}}, b}) *
                               HASH_PRIME;
                    if (cache_valid[msg_topic] && msg_len < cache_len[msg_topic] &&
                        cache_bytes[msg_topic][cache_bank[msg_topic]][msg_len] != b)
                        msg_diffs++;
                    cache_bytes[msg_topic][~cache_bank[msg_topic]][msg_len] = b;
                    msg_len++;
                end else begin
                    msg_overflow = 1'b1;
                end
                if (is_last)
                    close_message();
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            detect_change(in_if.action, in_if.topic, in_if.data_byte, in_if.last);
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_error($sformatf("unexpected result for topic %0d", out_if.result_topic));
            end else begin
                want = pending_verdicts.pop_front();
                check_field("result_topic", int'(out_if.result_topic), int'(want.topic));
                check_field("changed", int'(out_if.changed), int'(want.changed));
                check_field("overflow", int'(out_if.overflow), int'(want.overflow));
                check_field("message_length", int'(out_if.message_length),
                            int'(want.msg_length));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver: random stall modes, plus one long hold-off on request
    initial begin
        t_rx_mode rx_mode;
        int mode_left;
        int phase;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        phase     = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                phase++;
                case (rx_mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_COIN:   out_if.ready <= 1'($urandom);
                    RX_SPARSE: out_if.ready <= (phase % 4 == 0);
                    default:   out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [mcd_pkg::ACTION_W-1:0] act,
                             input logic [mcd_pkg::TOPIC_W-1:0] t,
                             input logic [mcd_pkg::BYTE_W-1:0] b, input logic is_last);
        int gap;
        gap = 0;
        if (!steady_send) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= act;
        in_if.topic     <= t;
        in_if.data_byte <= b;
        in_if.last      <= is_last;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    // topic field of the later bytes is random, the block must ignore it
    task automatic send_message(input logic [mcd_pkg::TOPIC_W-1:0] t, input t_byte_q msg);
        if (msg.size() == 0) begin
            send_item(mcd_pkg::ACT_EMPTY, t, 8'($urandom), 1'($urandom));
        end else begin
            foreach (msg[i])
                send_item(mcd_pkg::ACT_BYTE, (i == 0) ? t : 4'($urandom), msg[i],
                          i == msg.size() - 1);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_diff_threshold(input logic [mcd_pkg::THR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        diff_limit = int'(value);
    endtask

    task automatic test_directed_cases();
        send_message(4'd0, {8'h00, 8'hff});           // no entry yet
        send_message(4'd0, {8'h00, 8'hff});           // identical repeat
        send_message(4'd0, {8'h00, 8'hfe});           // one byte differs
        send_message(4'd0, {8'h00});                  // shorter message
        send_item(mcd_pkg::ACT_EMPTY, 4'd15, 8'h00, 1'b0);
        send_item(mcd_pkg::ACT_EMPTY, 4'd15, 8'hff, 1'b1);     // empty repeat
        send_message(4'd15, {8'ha5, 8'h5a});
        send_message(4'd15, {8'ha5, 8'h5a});
        send_item(mcd_pkg::ACT_CLEAR, 4'd15, 8'h00, 1'b0);
        send_message(4'd15, {8'ha5, 8'h5a});          // cleared entry
        // clear lands in the middle of a message
        send_item(mcd_pkg::ACT_BYTE, 4'd15, 8'ha5, 1'b0);
        send_item(mcd_pkg::ACT_CLEAR, 4'd15, 8'hff, 1'b1);
        send_item(mcd_pkg::ACT_BYTE, 4'd2, 8'h5a, 1'b1);
        // empty message drops the partial one
        send_item(mcd_pkg::ACT_BYTE, 4'd0, 8'h11, 1'b0);
        send_item(mcd_pkg::ACT_EMPTY, 4'd7, 8'h00, 1'b0);
        send_item(mcd_pkg::ACT_BYTE, 4'd0, 8'h00, 1'b1);
        send_item(mcd_pkg::ACT_CLEAR_ALL, 4'd9, 8'h33, 1'b1);
        send_item(mcd_pkg::ACT_BYTE, 4'd0, 8'h00, 1'b1);
        drain_results();
    endtask

    task automatic test_long_messages();
        t_byte_q over_msg;
        repeat (MAX_LEN + 1) over_msg = {over_msg, 8'($urandom)};
        send_message(4'd9, over_msg);   // truncated, still counts as changed
        send_message(4'd9, {8'h01});
        drain_results();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        steady_send  = 1'b1;
        repeat (30) send_item(mcd_pkg::ACT_BYTE, 4'($urandom), 8'($urandom), 1'b1);
        steady_send = 1'b0;
        drain_results();
    endtask

    task automatic run_random_traffic(input int item_budget);
        int stop_at;
        int pick;
        int n;
        logic [mcd_pkg::TOPIC_W-1:0] t;
        logic [mcd_pkg::TOPIC_W-1:0] u;
        t_byte_q msg;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            steady_send = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            t    = 4'($urandom);
            if (pick < 5) begin
                send_item(mcd_pkg::ACT_CLEAR, t, 8'($urandom), 1'($urandom));
            end else if (pick < 7) begin
                send_item(mcd_pkg::ACT_CLEAR_ALL, t, 8'($urandom), 1'($urandom));
            end else if (pick < 12) begin
                send_item(mcd_pkg::ACT_EMPTY, t, 8'($urandom), 1'($urandom));
                recent_msgs[t].delete();
            end else if (pick < 17) begin
                // partial message cut off by an empty one
                n = $urandom_range(1, 3);
                repeat (n) send_item(mcd_pkg::ACT_BYTE, t, 8'($urandom), 1'b0);
                u = 4'($urandom);
                send_item(mcd_pkg::ACT_EMPTY, u, 8'($urandom), 1'($urandom));
                recent_msgs[u].delete();
            end else begin
                msg  = recent_msgs[t];
                pick = $urandom_range(0, 9);
                if (msg.size() == 0 || pick >= 6) begin
                    msg.delete();
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
                    repeat (n) msg = {msg, 8'($urandom)};
                end else if (pick >= 4) begin
                    msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
                end
                send_message(t, msg);
                recent_msgs[t] = msg;
            end
        end
        steady_send = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        set_diff_threshold(9'd256);
        run_random_traffic(RANDOM_ITEMS);
        set_diff_threshold(9'd1);
        run_random_traffic(RANDOM_ITEMS);
        set_diff_threshold(9'($urandom_range(2, 255)));
        run_random_traffic(RANDOM_ITEMS);
        set_diff_threshold(9'd0);
        run_random_traffic(RANDOM_ITEMS);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_if.valid     = 1'b0;
        in_if.action    = mcd_pkg::ACT_BYTE;
        in_if.topic     = '0;
        in_if.data_byte = '0;
        in_if.last      = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_long_messages();
        test_output_backpressure();
        test_random_traffic();
        drain_results();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
